/* hw/rtl/tti_pkg.sv */
`default_nettype none

package tti_pkg;

  typedef enum logic [1:0] {
    OP_SIN = 2'd0,
    OP_COS = 2'd1,
    OP_TAN = 2'd2,
    OP_COT = 2'd3
  } op_t;

  localparam int unsigned SINE_ENTRIES     = 360;
  localparam int unsigned ANGLE_FRAC_BITS  = 8;
  localparam int unsigned RESULT_FRAC_BITS = 16;

  localparam int unsigned IDX_W     = $clog2(SINE_ENTRIES);
  localparam int unsigned N_W       = $clog2(SINE_ENTRIES + 1);
  localparam int unsigned ROM_DEPTH = 2 * SINE_ENTRIES;
  localparam int unsigned ROM_AW    = $clog2(ROM_DEPTH);
  localparam int unsigned TAN_DEN   = 2 * SINE_ENTRIES;

  localparam int unsigned DEG_W = 9;
  localparam int unsigned R_W   = DEG_W + ANGLE_FRAC_BITS;
  localparam int unsigned REM_W = R_W;
  localparam int unsigned P_W   = R_W + N_W;
  localparam int unsigned S_W   = 33;
  localparam int unsigned HI_W  = S_W - ANGLE_FRAC_BITS;
  localparam int unsigned U_W   = HI_W + 1;

  localparam int unsigned DIVISOR   = 180;
  localparam int unsigned DIV_W     = (U_W > 30) ? U_W : 30;
  localparam int unsigned DIV_SHIFT = DIV_W + 8;
  localparam int unsigned RECIP_W   = DIV_W + 1;
  localparam int unsigned DIV_QW    = DIV_W - 7;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'((64'd1 << DIV_SHIFT) / 64'd180);

  localparam int unsigned DIFF_W = 33;
  localparam int unsigned PR_W   = DIFF_W + REM_W;
  localparam int unsigned X_W    = PR_W + 1;
  localparam int unsigned Y_W    = X_W - ANGLE_FRAC_BITS;
  localparam int unsigned YL_W   = DIV_W - 8;
  localparam int unsigned YH_W   = Y_W - YL_W;
  localparam int unsigned QH_W   = YH_W - 7;
  localparam int unsigned Q_W    = QH_W + YL_W;
  localparam int unsigned V_W    = Q_W + 2;

  localparam logic signed [S_W-1:0] NINETY_A = S_W'(90 * (1 << ANGLE_FRAC_BITS));
  localparam logic [63:0] ANG_BIAS64 =
    (((64'd1 << (HI_W - 1)) + 64'd359) / 64'd360) * 64'd360;
  localparam logic [U_W-1:0] ANG_BIAS = U_W'(ANG_BIAS64);
  localparam logic [REM_W-1:0] D180_R = REM_W'(180 * (1 << ANGLE_FRAC_BITS));
  localparam logic [X_W-1:0] HALF_D180 = X_W'(90 * (1 << ANGLE_FRAC_BITS));
  localparam logic [X_W-1:0] HALF_D360 = X_W'(180 * (1 << ANGLE_FRAC_BITS));
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SINE_ENTRIES - 1);

  typedef struct packed {
    logic tan;
    logic flag;
    logic below;
    logic near90;
  } ctl_t;

  typedef logic [63:0] u64_t;
  typedef u64_t hdiv_t [1:7];
  typedef logic signed [31:0] rom_t [ROM_DEPTH];

  typedef struct packed {
    logic [1:0] q;
    u64_t       s;
    u64_t       c;
  } trig_q30_t;

  localparam u64_t  Q30_ONE     = 64'd1 << 30;
  localparam u64_t  HALF_PI_Q30 = 64'd1686629713;
  localparam u64_t  TAN_CAP     = 64'd1 << 40;
  localparam hdiv_t SIN_HDIV    = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};
  localparam hdiv_t COS_HDIV    = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182};

  function automatic u64_t horner(input u64_t x2, input logic for_sine);
    u64_t t;
    u64_t pr;
    u64_t y;
    t = Q30_ONE;
    for (int n = 7; n >= 1; n--) begin
      pr = (x2 * t) >> 30;
      y  = for_sine ? pr / SIN_HDIV[n] : pr / COS_HDIV[n];
      t  = (y > Q30_ONE) ? 64'd0 : Q30_ONE - y;
    end
    return t;
  endfunction

  function automatic trig_q30_t sincos(input u64_t num, input logic tan_grid);
    trig_q30_t r;
    u64_t      q;
    u64_t      rem;
    u64_t      x;
    u64_t      x2;
    if (tan_grid) begin
      q   = (4 * num) / TAN_DEN;
      rem = (4 * num) % TAN_DEN;
      x   = (rem * HALF_PI_Q30) / TAN_DEN;
    end else begin
      q   = (4 * num) / SINE_ENTRIES;
      rem = (4 * num) % SINE_ENTRIES;
      x   = (rem * HALF_PI_Q30) / SINE_ENTRIES;
    end
    x2  = (x * x) >> 30;
    r.q = q[1:0];
    r.s = (x * horner(x2, 1'b1)) >> 30;
    r.c = horner(x2, 1'b0);
    return r;
  endfunction

  function automatic u64_t q30_to_result(input u64_t m);
    return (m + (64'd1 << (29 - RESULT_FRAC_BITS))) >> (30 - RESULT_FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic u64_t udiv(input u64_t n, input u64_t d);
    u64_t rem;
    u64_t quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= d) begin
        rem    = rem - d;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sine cells first, then tangent cells.
  function automatic rom_t build_rom();
    rom_t               rom;
    trig_q30_t          sc;
    logic signed [63:0] v;
    u64_t               numr;
    u64_t               denr;
    u64_t               mag;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      sc     = sincos(u64_t'(k), 1'b0);
      v      = signed'(q30_to_result(sc.q[0] ? sc.c : sc.s));
      rom[k] = sat32(sc.q[1] ? -v : v);
      sc     = sincos(u64_t'(k), 1'b1);
      numr   = sc.q[0] ? sc.c : sc.s;
      denr   = sc.q[0] ? sc.s : sc.c;
      v      = '0;
      if (denr != 64'd0) begin
        mag = udiv((numr << RESULT_FRAC_BITS) + (denr >> 1), denr);
        if (mag > TAN_CAP) begin
          mag = TAN_CAP;
        end
        v = sc.q[0] ? -signed'(mag) : signed'(mag);
      end
      rom[SINE_ENTRIES + k] = sat32(v);
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tti_div180.sv */
`default_nettype none

module tti_div180 import tti_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [DIV_W-1:0]  dividend,
  output logic              vld_r,
  output logic [DIV_QW-1:0] quo_r,
  output logic [7:0]        rem_r
);

  localparam logic [DIV_W-1:0] DIVISOR_V = DIV_W'(DIVISOR);

  logic                     vld_a_r;
  logic [DIV_W-1:0]         dvd_r;
  logic [DIV_W+RECIP_W-1:0] prod_r;
  logic [DIV_QW-1:0]        q0;
  logic [DIV_W-1:0]         r0;
  logic [DIV_QW-1:0]        quo_nxt;
  logic [DIV_W-1:0]         rem_nxt;

  // The reciprocal estimate is at most one below the true quotient.
  always_comb begin
    q0 = prod_r[DIV_SHIFT +: DIV_QW];
    r0 = dvd_r - (DIV_W'(q0) * DIVISOR_V);
    if (r0 >= DIVISOR_V) begin
      quo_nxt = q0 + 1'b1;
      rem_nxt = r0 - DIVISOR_V;
    end else begin
      quo_nxt = q0;
      rem_nxt = r0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
      vld_r   <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dividend;
    prod_r <= (DIV_W + RECIP_W)'(dividend) * (DIV_W + RECIP_W)'(DIV_RECIP);
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt[7:0];
  end

endmodule

`default_nettype wire

/* hw/rtl/tti_rom.sv */
`default_nettype none

module tti_rom import tti_pkg::*; (
  input  logic                clk,
  input  logic [ROM_AW-1:0]   addr_a,
  input  logic [ROM_AW-1:0]   addr_b,
  output logic signed [31:0]  data_a_r,
  output logic signed [31:0]  data_b_r
);

  localparam rom_t TRIG_ROM = build_rom();

  always_ff @(posedge clk) begin
    data_a_r <= TRIG_ROM[addr_a];
    data_b_r <= TRIG_ROM[addr_b];
  end

endmodule

`default_nettype wire

/* hw/rtl/trig_table_interpolator.sv */
// Channel   Ports                                   Transaction
// input     start, busy, in_operation, in_angle     start high while busy low
// result    out_valid, out_value, out_undefined_angle  one cycle, out_valid high
//
// One transaction is taken every cycle; busy is always low.
// Each result comes out in order, through a pipeline of adders, multipliers,
// constant-divisor units and a two-port table read.
// Reset empties the pipeline; no results come out of reset.
// The receiver cannot stall, so nothing ever holds the pipeline.
`default_nettype none

module trig_table_interpolator import tti_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic signed [31:0] in_angle,
  output logic               out_valid,
  output logic signed [31:0] out_value,
  output logic               out_undefined_angle
);

  localparam logic [P_W-1:0]      ENTRIES_P = P_W'(SINE_ENTRIES);
  localparam logic [IDX_W+1:0]    ENTRIES_T = (IDX_W + 2)'(SINE_ENTRIES);
  localparam logic [ROM_AW-1:0]   TAN_BASE  = ROM_AW'(SINE_ENTRIES);
  localparam logic signed [V_W-1:0] SAT_HI  = V_W'(32'sh7fffffff);
  localparam logic signed [V_W-1:0] SAT_LO  = V_W'(32'sh80000000);

  op_t op;

  logic signed [S_W-1:0] a_ext;
  logic signed [S_W-1:0] s0_s_nxt;
  logic signed [S_W-1:0] s0_s_r;
  logic                  s0_tan_r;
  logic                  s0_vld_r;

  logic signed [HI_W-1:0]     hi;
  logic [U_W-1:0]             u_nxt;
  logic [DIV_W-1:0]           s1_u_r;
  logic [ANGLE_FRAC_BITS-1:0] s1_frac_r;
  logic                       s1_tan_r;
  logic                       s1_vld_r;

  logic                       d1_vld;
  logic [DIV_QW-1:0]          d1_quo;
  logic [7:0]                 d1_rem;
  logic [ANGLE_FRAC_BITS-1:0] d1a_frac_r;
  logic [ANGLE_FRAC_BITS-1:0] d1b_frac_r;
  logic                       d1a_tan_r;
  logic                       d1b_tan_r;

  logic [DEG_W-1:0] r_deg;
  logic [R_W-1:0]   r_ang;
  ctl_t             s2_ctl_nxt;
  logic [P_W-1:0]   s2_p_r;
  ctl_t             s2_ctl_r;
  logic             s2_vld_r;

  logic                       d2_vld;
  logic [DIV_QW-1:0]          d2_quo;
  logic [7:0]                 d2_rem;
  logic [ANGLE_FRAC_BITS-1:0] d2a_pfrac_r;
  logic [ANGLE_FRAC_BITS-1:0] d2b_pfrac_r;
  ctl_t                       d2a_ctl_r;
  ctl_t                       d2b_ctl_r;

  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  idx_next;
  logic [IDX_W+1:0]  twice;
  logic [REM_W-2:0]  rem180;
  logic [REM_W-1:0]  rem_nxt;
  ctl_t              s3_ctl_nxt;
  logic [ROM_AW-1:0] s3_addr_a_r;
  logic [ROM_AW-1:0] s3_addr_b_r;
  logic [REM_W-1:0]  s3_rem_r;
  ctl_t              s3_ctl_r;
  logic              s3_vld_r;

  logic signed [31:0] rom_lo;
  logic signed [31:0] rom_hi;
  logic [REM_W-1:0]   s4_rem_r;
  ctl_t               s4_ctl_r;
  logic               s4_vld_r;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        s5_mag_r;
  logic                     s5_neg_r;
  logic signed [31:0]       s5_lo_r;
  logic [REM_W-1:0]         s5_rem_r;
  ctl_t                     s5_ctl_r;
  logic                     s5_vld_r;

  logic [PR_W-1:0]    s6_prod_r;
  logic               s6_neg_r;
  logic signed [31:0] s6_lo_r;
  ctl_t               s6_ctl_r;
  logic               s6_vld_r;

  logic [X_W-1:0]     x_sum;
  logic [Y_W-1:0]     s7_y_r;
  logic               s7_neg_r;
  logic signed [31:0] s7_lo_r;
  ctl_t               s7_ctl_r;
  logic               s7_vld_r;

  logic               d3_vld;
  logic [DIV_QW-1:0]  d3_quo;
  logic [7:0]         d3_rem;
  logic [YL_W-1:0]    d3a_yl_r;
  logic [YL_W-1:0]    d3b_yl_r;
  logic               d3a_neg_r;
  logic               d3b_neg_r;
  logic signed [31:0] d3a_lo_r;
  logic signed [31:0] d3b_lo_r;
  ctl_t               d3a_ctl_r;
  ctl_t               d3b_ctl_r;

  logic               d4_vld;
  logic [DIV_QW-1:0]  d4_quo;
  logic [7:0]         d4_rem;
  logic [QH_W-1:0]    d4a_qh_r;
  logic [QH_W-1:0]    d4b_qh_r;
  logic               d4a_neg_r;
  logic               d4b_neg_r;
  logic signed [31:0] d4a_lo_r;
  logic signed [31:0] d4b_lo_r;
  ctl_t               d4a_ctl_r;
  ctl_t               d4b_ctl_r;

  logic [Q_W-1:0]        q_all;
  logic [Q_W-1:0]        q_sel;
  logic signed [V_W-1:0] q_v;
  logic signed [V_W-1:0] v_sum;
  logic signed [31:0]    value_nxt;
  logic                  out_vld_r;
  logic signed [31:0]    out_value_r;
  logic                  out_undef_r;

  assign busy = 1'b0;
  assign op   = op_t'(in_operation);

  // Angle select: cosine shifts by ninety, cotangent mirrors about ninety.
  always_comb begin
    a_ext = S_W'(in_angle);
    unique case (op)
      OP_SIN, OP_TAN: s0_s_nxt = a_ext;
      OP_COS:         s0_s_nxt = a_ext + NINETY_A;
      OP_COT:         s0_s_nxt = NINETY_A - a_ext;
    endcase
  end

  // Whole degrees are biased by a multiple of 360 so the reduction is unsigned.
  assign hi    = s0_s_r[S_W-1:ANGLE_FRAC_BITS];
  assign u_nxt = U_W'(hi) + ANG_BIAS;

  tti_div180 u_div_ang (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s1_vld_r),
    .dividend (s1_u_r),
    .vld_r    (d1_vld),
    .quo_r    (d1_quo),
    .rem_r    (d1_rem)
  );

  always_comb begin
    r_deg = DEG_W'(d1_rem) + ((!d1b_tan_r && d1_quo[0]) ? DEG_W'(180) : '0);
    r_ang = {r_deg, d1b_frac_r};
    s2_ctl_nxt.tan    = d1b_tan_r;
    s2_ctl_nxt.flag   = d1b_tan_r && (r_deg == DEG_W'(90)) && (d1b_frac_r == '0);
    s2_ctl_nxt.below  = r_deg < DEG_W'(90);
    s2_ctl_nxt.near90 = 1'b0;
  end

  tti_div180 u_div_idx (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s2_vld_r),
    .dividend (DIV_W'(s2_p_r[P_W-1:ANGLE_FRAC_BITS])),
    .vld_r    (d2_vld),
    .quo_r    (d2_quo),
    .rem_r    (d2_rem)
  );

  always_comb begin
    idx      = d2b_ctl_r.tan ? d2_quo[IDX_W-1:0] : d2_quo[IDX_W:1];
    idx_next = (idx == IDX_LAST) ? '0 : idx + 1'b1;
    rem180   = {d2_rem, d2b_pfrac_r};
    rem_nxt  = REM_W'(rem180) + ((!d2b_ctl_r.tan && d2_quo[0]) ? D180_R : '0);
    twice    = {1'b0, idx, 1'b0};
    s3_ctl_nxt        = d2b_ctl_r;
    s3_ctl_nxt.near90 = d2b_ctl_r.tan && (twice <= ENTRIES_T) &&
                        (ENTRIES_T <= twice + (IDX_W + 2)'(2));
  end

  tti_rom u_rom (
    .clk      (clk),
    .addr_a   (s3_addr_a_r),
    .addr_b   (s3_addr_b_r),
    .data_a_r (rom_lo),
    .data_b_r (rom_hi)
  );

  assign diff  = DIFF_W'(rom_hi) - DIFF_W'(rom_lo);
  assign x_sum = X_W'(s6_prod_r) + (s6_ctl_r.tan ? HALF_D180 : HALF_D360);

  tti_div180 u_div_hi (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s7_vld_r),
    .dividend (DIV_W'(s7_y_r[Y_W-1:YL_W])),
    .vld_r    (d3_vld),
    .quo_r    (d3_quo),
    .rem_r    (d3_rem)
  );

  tti_div180 u_div_lo (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (d3_vld),
    .dividend ({d3_rem, d3b_yl_r}),
    .vld_r    (d4_vld),
    .quo_r    (d4_quo),
    .rem_r    (d4_rem)
  );

  always_comb begin
    q_all = {d4b_qh_r, d4_quo[YL_W-1:0]};
    q_sel = d4b_ctl_r.tan ? q_all : (q_all >> 1);
    q_v   = signed'(V_W'(q_sel));
    v_sum = V_W'(d4b_lo_r) + (d4b_neg_r ? -q_v : q_v);
    priority if (d4b_ctl_r.flag) begin
      value_nxt = '0;
    end else if (d4b_ctl_r.near90) begin
      value_nxt = d4b_ctl_r.below ? 32'sh7fffffff : 32'sh80000000;
    end else if (v_sum > SAT_HI) begin
      value_nxt = 32'sh7fffffff;
    end else if (v_sum < SAT_LO) begin
      value_nxt = 32'sh80000000;
    end else begin
      value_nxt = v_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      s7_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s0_vld_r  <= start && !busy;
      s1_vld_r  <= s0_vld_r;
      s2_vld_r  <= d1_vld;
      s3_vld_r  <= d2_vld;
      s4_vld_r  <= s3_vld_r;
      s5_vld_r  <= s4_vld_r;
      s6_vld_r  <= s5_vld_r;
      s7_vld_r  <= s6_vld_r;
      out_vld_r <= d4_vld;
    end
  end

  always_ff @(posedge clk) begin
    s0_s_r      <= s0_s_nxt;
    s0_tan_r    <= (op == OP_TAN) || (op == OP_COT);

    s1_u_r      <= DIV_W'(u_nxt);
    s1_frac_r   <= s0_s_r[ANGLE_FRAC_BITS-1:0];
    s1_tan_r    <= s0_tan_r;

    d1a_frac_r  <= s1_frac_r;
    d1a_tan_r   <= s1_tan_r;
    d1b_frac_r  <= d1a_frac_r;
    d1b_tan_r   <= d1a_tan_r;

    s2_p_r      <= P_W'(r_ang) * ENTRIES_P;
    s2_ctl_r    <= s2_ctl_nxt;

    d2a_pfrac_r <= s2_p_r[ANGLE_FRAC_BITS-1:0];
    d2a_ctl_r   <= s2_ctl_r;
    d2b_pfrac_r <= d2a_pfrac_r;
    d2b_ctl_r   <= d2a_ctl_r;

    s3_addr_a_r <= d2b_ctl_r.tan ? TAN_BASE + ROM_AW'(idx) : ROM_AW'(idx);
    s3_addr_b_r <= d2b_ctl_r.tan ? TAN_BASE + ROM_AW'(idx_next) : ROM_AW'(idx_next);
    s3_rem_r    <= rem_nxt;
    s3_ctl_r    <= s3_ctl_nxt;

    s4_rem_r    <= s3_rem_r;
    s4_ctl_r    <= s3_ctl_r;

    s5_mag_r    <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    s5_neg_r    <= diff[DIFF_W-1];
    s5_lo_r     <= rom_lo;
    s5_rem_r    <= s4_rem_r;
    s5_ctl_r    <= s4_ctl_r;

    s6_prod_r   <= PR_W'(s5_mag_r) * PR_W'(s5_rem_r);
    s6_neg_r    <= s5_neg_r;
    s6_lo_r     <= s5_lo_r;
    s6_ctl_r    <= s5_ctl_r;

    s7_y_r      <= x_sum[X_W-1:ANGLE_FRAC_BITS];
    s7_neg_r    <= s6_neg_r;
    s7_lo_r     <= s6_lo_r;
    s7_ctl_r    <= s6_ctl_r;

    d3a_yl_r    <= s7_y_r[YL_W-1:0];
    d3a_neg_r   <= s7_neg_r;
    d3a_lo_r    <= s7_lo_r;
    d3a_ctl_r   <= s7_ctl_r;
    d3b_yl_r    <= d3a_yl_r;
    d3b_neg_r   <= d3a_neg_r;
    d3b_lo_r    <= d3a_lo_r;
    d3b_ctl_r   <= d3a_ctl_r;

    d4a_qh_r    <= d3_quo[QH_W-1:0];
    d4a_neg_r   <= d3b_neg_r;
    d4a_lo_r    <= d3b_lo_r;
    d4a_ctl_r   <= d3b_ctl_r;
    d4b_qh_r    <= d4a_qh_r;
    d4b_neg_r   <= d4a_neg_r;
    d4b_lo_r    <= d4a_lo_r;
    d4b_ctl_r   <= d4a_ctl_r;

    out_value_r <= value_nxt;
    out_undef_r <= d4b_ctl_r.flag;
  end

  // The low remainder is exact by construction and is not needed.
  logic unused_rem;
  assign unused_rem = ^d4_rem;

  assign out_valid           = out_vld_r;
  assign out_value           = out_value_r;
  assign out_undefined_angle = out_undef_r;

endmodule

`default_nettype wire
